[rtl/sfd_pkg.sv]
package sfd_pkg;

  localparam logic [7:0] SYNC_BYTE       = 8'h7f;
  localparam logic [1:0] SYNC_NEEDED     = 2'd3;
  localparam logic [2:0] RECORD_LAST_POS = 3'd4;   // fifth byte of a record
  localparam int         RECORDS_DEFAULT = 7;

  // one payload byte on its way from the classifier to the assembler
  typedef struct packed {
    logic [7:0] data;
    logic       rec_done;   // fifth byte of a record
    logic       frame_last;
    logic [2:0] index;
    logic [7:0] status;
  } sfd_word_t;

endpackage

[rtl/sfd_front.sv]
module sfd_front import sfd_pkg::*; #(
  parameter int RECORDS_PER_FRAME = RECORDS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output sfd_word_t  push_word
);

  localparam logic [2:0] REC_LAST = 3'(RECORDS_PER_FRAME - 1);

  logic [1:0] sync_cnt_r, sync_cnt_nxt;
  logic       in_payload_r, in_payload_nxt;
  logic [7:0] status_r, status_nxt;
  logic [2:0] rec_r, rec_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       accept;
  logic       done;
  logic       last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign done     = (pos_r == RECORD_LAST_POS);
  assign last     = (rec_r == REC_LAST);

  assign push                 = accept && in_payload_r;
  assign push_word.data       = in_data_byte;
  assign push_word.rec_done   = done;
  assign push_word.frame_last = last;
  assign push_word.index      = rec_r;
  assign push_word.status     = status_r;

  always_comb begin
    sync_cnt_nxt   = sync_cnt_r;
    in_payload_nxt = in_payload_r;
    status_nxt     = status_r;
    rec_nxt        = rec_r;
    pos_nxt        = pos_r;
    if (accept) begin
      if (!in_payload_r) begin
        if (sync_cnt_r != SYNC_NEEDED) begin
          sync_cnt_nxt = (in_data_byte == SYNC_BYTE) ? sync_cnt_r + 2'd1 : 2'd0;
        end else begin
          // status byte, taken as is even when it looks like sync
          status_nxt     = in_data_byte;
          in_payload_nxt = 1'b1;
          sync_cnt_nxt   = 2'd0;
          rec_nxt        = 3'd0;
          pos_nxt        = 3'd0;
        end
      end else if (done) begin
        pos_nxt = 3'd0;
        if (last) begin
          in_payload_nxt = 1'b0;
          rec_nxt        = 3'd0;
        end else begin
          rec_nxt = rec_r + 3'd1;
        end
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_cnt_r   <= 2'd0;
      in_payload_r <= 1'b0;
      status_r     <= 8'd0;
      rec_r        <= 3'd0;
      pos_r        <= 3'd0;
    end else begin
      sync_cnt_r   <= sync_cnt_nxt;
      in_payload_r <= in_payload_nxt;
      status_r     <= status_nxt;
      rec_r        <= rec_nxt;
      pos_r        <= pos_nxt;
    end
  end

endmodule

[rtl/sfd_queue.sv]
module sfd_queue import sfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sfd_word_t push_word,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output sfd_word_t head
);

  // two-entry FIFO
  sfd_word_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/sfd_back.sv]
module sfd_back import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  sfd_word_t   head,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_foot_right,
  output logic [6:0]  out_shoe_status,
  output logic [2:0]  out_chamber_index,
  output logic [15:0] out_chamber_height,
  output logic [23:0] out_chamber_pressure,
  output logic        out_frame_last
);

  logic [31:0] acc_r;          // first four bytes of the record
  logic        out_valid_r;
  logic        foot_r;
  logic [6:0]  status_r;
  logic [2:0]  index_r;
  logic [15:0] height_r;
  logic [23:0] pressure_r;
  logic        last_r;
  logic        slot_free;
  logic        emit;

  assign slot_free = !out_valid_r || out_ready;
  assign pop       = !q_empty && (!head.rec_done || slot_free);
  assign emit      = pop && head.rec_done;

  always_ff @(posedge clk) begin
    if (pop && !head.rec_done) begin
      acc_r <= {acc_r[23:0], head.data};
    end
    if (emit) begin
      foot_r     <= head.status[7];
      status_r   <= head.status[6:0];
      index_r    <= head.index;
      height_r   <= acc_r[31:16];
      pressure_r <= {acc_r[15:0], head.data};
      last_r     <= head.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_foot_right       = foot_r;
  assign out_shoe_status      = status_r;
  assign out_chamber_index    = index_r;
  assign out_chamber_height   = height_r;
  assign out_chamber_pressure = pressure_r;
  assign out_frame_last       = last_r;

endmodule

[rtl/sensor_frame_deframer_core.sv]
// A record's fifth byte is registered in the two-entry queue, then in the result register.
// Throughput: one byte per cycle while in_ready is high; one result per five payload bytes.
// in_ready drops only when the two-entry queue is full (result register stalled).
// Reset: synchronous active-low rst_n clears hunt state, queue and out_valid;
// the block starts hunting for three sync bytes.
module sensor_frame_deframer_core import sfd_pkg::*; #(
  parameter int RECORDS_PER_FRAME = RECORDS_DEFAULT   // 1..8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_foot_right,
  output logic [6:0]  out_shoe_status,
  output logic [2:0]  out_chamber_index,
  output logic [15:0] out_chamber_height,
  output logic [23:0] out_chamber_pressure,
  output logic        out_frame_last
);

  // front: sync hunt, status latch, record/byte tracking; tags payload words
  // queue: decouples front from the result register
  // back:  assembles height/pressure and holds the result word
  logic      push, pop, q_full, q_empty;
  sfd_word_t push_word, head;

  sfd_front #(.RECORDS_PER_FRAME(RECORDS_PER_FRAME)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .in_ready     (in_ready),
    .push         (push),
    .push_word    (push_word)
  );

  sfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  sfd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .head                 (head),
    .pop                  (pop),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_foot_right       (out_foot_right),
    .out_shoe_status      (out_shoe_status),
    .out_chamber_index    (out_chamber_index),
    .out_chamber_height   (out_chamber_height),
    .out_chamber_pressure (out_chamber_pressure),
    .out_frame_last       (out_frame_last)
  );

endmodule

[rtl/sfd_checker.sv]
module sfd_checker import sfd_pkg::*; #(
  parameter int RECORDS_PER_FRAME = RECORDS_DEFAULT
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_foot_right,
  input logic [6:0]  out_shoe_status,
  input logic [2:0]  out_chamber_index,
  input logic [15:0] out_chamber_height,
  input logic [23:0] out_chamber_pressure,
  input logic        out_frame_last
);

  localparam logic [2:0] REC_LAST = 3'(RECORDS_PER_FRAME - 1);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte))
    else $error("input word dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chamber_pressure)
      && $stable(out_chamber_height) && $stable(out_chamber_index)
      && $stable(out_foot_right) && $stable(out_shoe_status)
      && $stable(out_frame_last))
    else $error("result word changed while stalled");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_chamber_index <= REC_LAST)
    else $error("chamber index beyond frame");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_last == (out_chamber_index == REC_LAST)))
    else $error("frame_last does not match final chamber");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

endmodule

bind sensor_frame_deframer_core sfd_checker #(.RECORDS_PER_FRAME(RECORDS_PER_FRAME)) u_sfd_chk (.*);

[bench/tb_sensor_frame_deframer_core.sv]
`timescale 1ns / 1ps

module tb_sensor_frame_deframer_core;
  import sfd_pkg::*;

  localparam int FRAME_RECORDS = RECORDS_DEFAULT;
  localparam int RECORD_BYTES  = RECORD_LAST_POS + 1;
  localparam int BYTE_TARGET   = 1650;
  localparam int QUIET_TAIL    = 200;     // last bytes sent with no idling on either side
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES  = 8;       // margin after the last expected record
  localparam int CYCLE_LIMIT   = 200000;

  // One chamber record as it leaves the block.
  typedef struct packed {
    logic        foot_right;
    logic [6:0]  shoe_status;
    logic [2:0]  chamber_index;
    logic [15:0] chamber_height;
    logic [23:0] chamber_pressure;
    logic        frame_last;
  } chamber_rec_t;

  // Where a directed row takes its expectation from.
  typedef enum logic [1:0] {
    REC_NONE,       // typed in: no record expected
    REC_TYPED,      // typed in: this record expected
    REC_PREDICTED   // whatever the deframer predictor says
  } rec_source_t;

  typedef struct {
    logic [7:0]   data;
    rec_source_t  source;
    chamber_rec_t rec;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_foot_right;
  logic [6:0]  out_shoe_status;
  logic [2:0]  out_chamber_index;
  logic [15:0] out_chamber_height;
  logic [23:0] out_chamber_pressure;
  logic        out_frame_last;

  sensor_frame_deframer_core #(
    .RECORDS_PER_FRAME (FRAME_RECORDS)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_foot_right       (out_foot_right),
    .out_shoe_status      (out_shoe_status),
    .out_chamber_index    (out_chamber_index),
    .out_chamber_height   (out_chamber_height),
    .out_chamber_pressure (out_chamber_pressure),
    .out_frame_last       (out_frame_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Deframer predictor: own copy of the hunt / payload state.
  // ---------------------------------------------------------------------------
  logic [1:0]  pr_sync_seen;
  logic        pr_in_payload;
  logic [7:0]  pr_status;
  logic [2:0]  pr_record;
  logic [2:0]  pr_pos;
  logic [39:0] pr_acc;

  chamber_rec_t expected_records[$];   // records still owed by the block
  stim_row_t    directed_rows[$];

  int unsigned bytes_sent     = 0;
  int unsigned records_seen   = 0;
  int unsigned frames_seen    = 0;
  int unsigned mismatches     = 0;
  int unsigned held_cycles    = 0;
  int unsigned cycle_count    = 0;
  bit          idle_on        = 1'b1;  // random gaps / stalls enabled
  bit          hold_request   = 1'b0;  // sender asks the receiver for one long hold-off

  function automatic void deframer_reset();
    pr_sync_seen  = '0;
    pr_in_payload = 1'b0;
    pr_status     = '0;
    pr_record     = '0;
    pr_pos        = '0;
    pr_acc        = '0;
  endfunction

  // Advance the predictor by one byte; returns 1 when a chamber record completes.
  function automatic bit deframe_byte(input logic [7:0] b, output chamber_rec_t rec);
    bit last;
    rec = '0;
    if (!pr_in_payload) begin
      if (pr_sync_seen < SYNC_NEEDED) begin
        // hunt: any non-sync byte restarts the count
        pr_sync_seen = (b == SYNC_BYTE) ? pr_sync_seen + 2'd1 : 2'd0;
        return 1'b0;
      end
      // byte after the third sync is always status, even 0x7f
      pr_status     = b;
      pr_in_payload = 1'b1;
      pr_sync_seen  = '0;
      pr_record     = '0;
      pr_pos        = '0;
      pr_acc        = '0;
      return 1'b0;
    end
    // payload: 0x7f is plain data here
    pr_acc = {pr_acc[31:0], b};
    if (pr_pos != RECORD_LAST_POS) begin
      pr_pos = pr_pos + 3'd1;
      return 1'b0;
    end
    last = (int'(pr_record) + 1 >= FRAME_RECORDS);
    rec.foot_right       = pr_status[7];
    rec.shoe_status      = pr_status[6:0];
    rec.chamber_index    = pr_record;
    rec.chamber_height   = pr_acc[39:24];
    rec.chamber_pressure = pr_acc[23:0];
    rec.frame_last       = last;
    pr_pos = '0;
    pr_acc = '0;
    if (last) begin
      pr_in_payload = 1'b0;
      pr_record     = '0;
    end else begin
      pr_record = pr_record + 3'd1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one word per byte. Drive at posedge, sample ready at negedge
  // (ready only moves at posedge, so the negedge value is the one the edge sees).
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b,
                           input rec_source_t source = REC_PREDICTED,
                           input chamber_rec_t typed = '0);
    chamber_rec_t rec;
    bit           took;
    bit           has_rec;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    // word accepted at this edge
    has_rec = deframe_byte(b, rec);
    case (source)
      REC_PREDICTED: if (has_rec) expected_records = {expected_records, rec};
      REC_TYPED:     expected_records = {expected_records, typed};
      default: ;
    endcase
    bytes_sent++;
  endtask

  task automatic add_row(input logic [7:0] b, input rec_source_t source,
                         input chamber_rec_t rec = '0);
    stim_row_t row;
    row.data   = b;
    row.source = source;
    row.rec    = rec;
    directed_rows = {directed_rows, row};
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == SYNC_BYTE);
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : drain_side
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          held_cycles++;
        end
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result checker, sampled mid-cycle like the sender.
  always @(negedge clk) begin : check_records
    chamber_rec_t want;
    chamber_rec_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_foot_right, out_shoe_status, out_chamber_index,
             out_chamber_height, out_chamber_pressure, out_frame_last};
      if (expected_records.size() == 0) begin
        $error("chamber record with none pending: index %0d height 0x%0h",
               got.chamber_index, got.chamber_height);
        mismatches++;
      end else begin
        want = expected_records.pop_front();
        check_field("foot_right",       24'(want.foot_right),       24'(got.foot_right));
        check_field("shoe_status",      24'(want.shoe_status),      24'(got.shoe_status));
        check_field("chamber_index",    24'(want.chamber_index),    24'(got.chamber_index));
        check_field("chamber_height",   24'(want.chamber_height),   24'(got.chamber_height));
        check_field("chamber_pressure", want.chamber_pressure,      got.chamber_pressure);
        check_field("frame_last",       24'(want.frame_last),       24'(got.frame_last));
      end
      records_seen++;
      if (got.frame_last) frames_seen++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sensor_frame_deframer_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned frame_no;
    logic [7:0]  b;
    deframer_reset();
    frame_no = 0;

    // Directed table. Typed rows are the ones readable at a glance.
    add_row(SYNC_BYTE, REC_NONE);
    add_row(8'h00,     REC_NONE);     // broken sync after one 0x7f
    add_row(SYNC_BYTE, REC_NONE);
    add_row(SYNC_BYTE, REC_NONE);
    add_row(8'hfe,     REC_NONE);     // broken sync after two 0x7f
    repeat (3) add_row(SYNC_BYTE, REC_NONE);
    add_row(SYNC_BYTE, REC_NONE);     // extra sync taken as status: left foot, 0x7f
    repeat (RECORD_BYTES - 1) add_row(8'hff, REC_NONE);
    add_row(8'hff, REC_TYPED, {1'b0, 7'h7f, 3'd0, 16'hffff, 24'hffffff, 1'b0});
    repeat (RECORD_BYTES - 1) add_row(8'h00, REC_NONE);
    add_row(8'h00, REC_TYPED, {1'b0, 7'h7f, 3'd1, 16'h0000, 24'h000000, 1'b0});
    // sync pattern inside the payload is plain data
    repeat (RECORD_BYTES) add_row(SYNC_BYTE, REC_PREDICTED);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].source, directed_rows[i].rec);

    // Random part: mostly well-formed frames with random content, some junk.
    while (bytes_sent < BYTE_TARGET) begin
      idle_on = (bytes_sent + QUIET_TAIL < BYTE_TARGET) && ($urandom_range(0, 3) != 0);
      if (frame_no == 3) hold_request = 1'b1;
      // finish whatever frame is open
      while (pr_in_payload) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(noise_byte());
        repeat ($urandom_range(1, 2)) send_byte(SYNC_BYTE);
        send_byte(noise_byte());
      end
      repeat (SYNC_NEEDED) send_byte(SYNC_BYTE);
      send_byte(($urandom_range(0, 7) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255)));
      repeat (FRAME_RECORDS * RECORD_BYTES) begin
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hff;
          2:       b = SYNC_BYTE;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b);
      end
      frame_no++;
    end
    in_valid <= 1'b0;

    while (expected_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d generated frames; %0d chamber records checked, %0d frame ends",
             bytes_sent, frame_no, records_seen, frames_seen);
    $display("receiver held off %0d cycles in one stretch to back up the input", held_cycles);
    if (mismatches == 0) begin
      $display("sensor_frame_deframer_core test passed");
    end else begin
      $display("sensor_frame_deframer_core test failed");
    end
    $finish;
  end

endmodule
